/* design/ptt_pkg.sv */
// Package for the periodic task timer: item structs, configuration struct,
// action codes and register indexes. It depends on nothing else.
package ptt_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [2:0] ACT_STEP    = 3'd0;
    localparam logic [2:0] ACT_PAUSE   = 3'd1;
    localparam logic [2:0] ACT_RESUME  = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_QUERY   = 3'd4;

    localparam logic [1:0] REG_USE_TIME      = 2'd0;
    localparam logic [1:0] REG_ONE_SHOT      = 2'd1;
    localparam logic [1:0] REG_PERIOD        = 2'd2;
    localparam logic [1:0] REG_INITIAL_DELAY = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic        fired;
        logic [63:0] remaining;
    } t_out_item;

    typedef struct packed {
        logic        use_time;
        logic        one_shot;
        logic [31:0] period;
        logic [31:0] initial_delay;
    } t_cfg;

endpackage

/* design/ptt_cfg.sv */
// APB-style configuration registers of the periodic task timer.
// Depends on ptt_pkg for the register indexes and the configuration struct.
module ptt_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptt_pkg::ADDR_W-1:0] paddr,
    input  logic [ptt_pkg::DATA_W-1:0] pwdata,
    output logic [ptt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ptt_pkg::t_cfg              o_cfg
);

    ptt_pkg::t_cfg r_cfg;
    logic          w_write;
    logic [1:0]    w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;
    assign w_index = paddr[ptt_pkg::ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_time      <= 1'b1;
            r_cfg.one_shot      <= 1'b0;
            r_cfg.period        <= 32'd0;
            r_cfg.initial_delay <= 32'd0;
        end else if (w_write) begin
            case (w_index)
                ptt_pkg::REG_USE_TIME:      r_cfg.use_time      <= pwdata[0];
                ptt_pkg::REG_ONE_SHOT:      r_cfg.one_shot      <= pwdata[0];
                ptt_pkg::REG_PERIOD:        r_cfg.period        <= pwdata;
                ptt_pkg::REG_INITIAL_DELAY: r_cfg.initial_delay <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            ptt_pkg::REG_USE_TIME:      prdata = {31'd0, r_cfg.use_time};
            ptt_pkg::REG_ONE_SHOT:      prdata = {31'd0, r_cfg.one_shot};
            ptt_pkg::REG_PERIOD:        prdata = r_cfg.period;
            ptt_pkg::REG_INITIAL_DELAY: prdata = r_cfg.initial_delay;
            default:                    prdata = '0;
        endcase
    end

endmodule

/* design/periodic_task_timer.sv */
// Periodic task timer: an item is accepted into an input register, worked on
// there and its result registered in an output register, from which it is
// offered. One item is taken every cycle while results drain.
// Synchronous reset clears the timer state and returns the configuration
// registers to their defaults. Depends on ptt_pkg and ptt_cfg.
module periodic_task_timer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ptt_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ptt_pkg::t_out_item         o_out_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptt_pkg::ADDR_W-1:0] paddr,
    input  logic [ptt_pkg::DATA_W-1:0] pwdata,
    output logic [ptt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    ptt_pkg::t_cfg      w_cfg;
    logic               r_in_valid;
    ptt_pkg::t_in_item  r_in;
    logic               r_out_valid;
    ptt_pkg::t_out_item r_out;
    ptt_pkg::t_out_item n_out;

    logic [63:0] r_stamp, n_stamp;
    logic [63:0] r_pause_start, n_pause_start;
    logic        r_paused, n_paused;
    logic [63:0] r_tick_count, n_tick_count;
    logic [31:0] r_delay_left, n_delay_left;
    logic        r_stopped, n_stopped;

    logic        w_advance;
    logic        w_run;
    logic [63:0] w_tick_inc;
    logic [63:0] w_now;
    logic [31:0] w_marker;
    logic [64:0] w_deadline;
    logic [64:0] w_gap;
    logic        w_ahead;
    logic [63:0] w_left;

    ptt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_run      = !r_paused && !r_stopped;
    assign w_tick_inc = r_tick_count + 64'd1;
    assign w_marker   = (r_delay_left != 32'd0) ? r_delay_left : w_cfg.period;

    always_comb begin
        if (w_cfg.use_time) begin
            w_now = r_in.time_now;
        end else if (r_in.action == ptt_pkg::ACT_STEP) begin
            w_now = w_tick_inc;
        end else begin
            w_now = r_tick_count;
        end
    end

    // The deadline is kept one bit wider so that it never wraps.
    assign w_deadline = {1'b0, r_stamp} + {33'd0, w_marker};
    assign w_gap      = w_deadline - {1'b0, w_now};
    assign w_ahead    = w_deadline > {1'b0, w_now};
    assign w_left     = !w_ahead ? 64'd0 : (w_gap[64] ? '1 : w_gap[63:0]);

    always_comb begin
        n_stamp       = r_stamp;
        n_pause_start = r_pause_start;
        n_paused      = r_paused;
        n_tick_count  = r_tick_count;
        n_delay_left  = r_delay_left;
        n_stopped     = r_stopped;
        n_out         = '0;
        case (r_in.action)
            ptt_pkg::ACT_STEP: begin
                if (w_run) begin
                    if (!w_cfg.use_time) begin
                        n_tick_count = w_tick_inc;
                    end
                    if (!w_ahead) begin
                        n_stamp      = w_deadline[63:0];
                        n_delay_left = 32'd0;
                        n_out.fired  = 1'b1;
                        if (w_cfg.one_shot) begin
                            n_stopped = 1'b1;
                        end
                    end
                end
            end
            ptt_pkg::ACT_PAUSE: begin
                if (!r_paused) begin
                    n_pause_start = w_now;
                    n_paused      = 1'b1;
                end
            end
            ptt_pkg::ACT_RESUME: begin
                if (r_paused) begin
                    n_stamp       = r_stamp + (w_now - r_pause_start);
                    n_pause_start = 64'd0;
                    n_paused      = 1'b0;
                end
            end
            ptt_pkg::ACT_RESTART: begin
                n_stopped    = 1'b0;
                n_stamp      = w_now;
                n_delay_left = w_cfg.initial_delay;
            end
            ptt_pkg::ACT_QUERY: begin
                n_out.remaining = w_left;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_stamp       <= 64'd0;
            r_pause_start <= 64'd0;
            r_paused      <= 1'b0;
            r_tick_count  <= 64'd0;
            r_delay_left  <= 32'd0;
            r_stopped     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid   <= 1'b1;
                r_stamp       <= n_stamp;
                r_pause_start <= n_pause_start;
                r_paused      <= n_paused;
                r_tick_count  <= n_tick_count;
                r_delay_left  <= n_delay_left;
                r_stopped     <= n_stopped;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule

/* design/ptt_checker.sv */
// Port-level checks for the periodic task timer, bound to its top level.
// Depends on ptt_pkg and periodic_task_timer.
module ptt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ptt_pkg::t_out_item o_out_item
);

    a_fired_no_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.fired |-> o_out_item.remaining == 64'd0)
        else $error("A fired result carries a nonzero remaining time.");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input not ready although no result is waiting.");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("A result is offered straight after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("A stalled result changed or was dropped.");

endmodule

bind periodic_task_timer ptt_checker u_ptt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
